[hdl/nsd_pkg.sv]
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants for the Netpbm stream decoder.
// ----------------------------------------------------------------------------
package nsd_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } nsd_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [2:0]  error_code;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic        final_pixel;
    logic        end_of_run;
  } nsd_out_t;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_MAGIC  = 3'd1;
  localparam logic [2:0] ERR_NUMBER = 3'd2;
  localparam logic [2:0] ERR_MAXVAL = 3'd3;
  localparam logic [2:0] ERR_SAMPLE = 3'd4;
  localparam logic [2:0] ERR_EXCESS = 3'd5;
  localparam logic [2:0] ERR_SHORT  = 3'd6;
  localparam logic [2:0] ERR_SIZE   = 3'd7;

  typedef enum logic [2:0] {
    PM_MAGIC, PM_WIDTH, PM_HEIGHT, PM_MAXVAL, PM_ASCII, PM_SEEK, PM_AFTER_CR, PM_BINARY
  } nsd_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_WORK, ST_RUN, ST_DONE
  } nsd_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // latch a new byte and process it
    logic run_bit;  // emit one P4 bit pixel
    logic finish;   // emit completion and clear
  } nsd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic has_run;  // latched byte starts a P4 bit run
    logic run_more; // more bits remain after the current one
    logic last;     // latched byte is final
  } nsd_stat_t;

  // integer 255/v for v in 1..255: the largest k with k*v <= 255
  function automatic logic [7:0] gray_div(input logic [7:0] v);
    logic [7:0] q;
    q = 8'd0;
    for (int k = 1; k < 256; k++) begin
      if (16'(v) * 16'(k) <= 16'd255) q = 8'(k);
    end
    return q;
  endfunction

endpackage

[hdl/nsd_ctrl.sv]
// ----------------------------------------------------------------------------
// nsd_ctrl
// Sequencer: takes a byte, runs P4 bit pixels one per cycle unless the output stalls, emits completion.
// ----------------------------------------------------------------------------
module nsd_ctrl
  import nsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      step_ok,
  input  nsd_stat_t stat,
  output nsd_cmd_t  cmd
);

  nsd_state_t state_r, state_nxt;

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && step_ok) state_nxt = ST_WORK;
      ST_WORK: begin
        if (step_ok) begin
          if (stat.has_run)   state_nxt = ST_RUN;
          else if (stat.last) state_nxt = ST_DONE;
          else                state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (step_ok && !stat.run_more) state_nxt = stat.last ? ST_DONE : ST_IDLE;
      end
      ST_DONE: if (step_ok) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = step_ok;
        cmd.load = in_valid && step_ok;
      end
      ST_WORK: ;
      ST_RUN:  cmd.run_bit = step_ok;
      ST_DONE: cmd.finish = step_ok;
      default: ;
    endcase
  end

endmodule

[hdl/nsd_dp.sv]
// ----------------------------------------------------------------------------
// nsd_dp
// Parser state, token arithmetic and pixel formation; one result per step.
// ----------------------------------------------------------------------------
module nsd_dp
  import nsd_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  nsd_in_t   in_data,
  input  nsd_cmd_t  cmd,
  input  logic      work,
  output nsd_stat_t stat,
  output logic      res_valid,
  output nsd_out_t  res_data
);

  localparam int TW = DIM_BITS + 1;
  localparam logic [TW-1:0] CAP = '1;

  nsd_mode_t       mode_r, mode_nxt;
  logic [2:0]      fmt_r, fmt_nxt;
  logic [DIM_BITS-1:0] wid_r, wid_nxt, hgt_r, hgt_nxt, col_r, col_nxt, row_r, row_nxt;
  logic [7:0]      maxv_r, maxv_nxt, gscale_r, gscale_nxt;
  logic [TW-1:0]   tok_r, tok_nxt;
  logic            tf_tok_r, tf_tok_nxt, tf_com_r, tf_com_nxt;
  logic            tf_neg_r, tf_neg_nxt, tf_bad_r, tf_bad_nxt;
  logic [3:0]      mp_r, mp_nxt;
  logic [1:0]      ch_r, ch_nxt;
  logic [15:0]     prg_r, prg_nxt;
  logic [2:0]      ferr_r, ferr_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            last_r, last_nxt;
  logic            run_nxt;
  logic [2:0]      bit_r, bit_nxt;

  // pending result of the work, run or finish step
  logic            pv;
  nsd_out_t        pd;

  function automatic logic full_f(input logic [DIM_BITS-1:0] w, h, r);
    return (w == '0) || (h == '0) || (r >= h);
  endfunction

  always_comb begin
    logic            ws, nl, cr, neg, bad;
    logic [TW+3:0]   prod;
    logic [7:0]      c, pix, v8;
    logic [DIM_BITS-1:0] c1;
    logic            sam, smp_go;
    logic [TW-1:0]   sv;
    logic            fin_tok;
    mode_nxt = mode_r; fmt_nxt = fmt_r; wid_nxt = wid_r; hgt_nxt = hgt_r;
    col_nxt = col_r; row_nxt = row_r; maxv_nxt = maxv_r; gscale_nxt = gscale_r;
    tok_nxt = tok_r; tf_tok_nxt = tf_tok_r; tf_com_nxt = tf_com_r;
    tf_neg_nxt = tf_neg_r; tf_bad_nxt = tf_bad_r; mp_nxt = mp_r; ch_nxt = ch_r;
    prg_nxt = prg_r; ferr_nxt = ferr_r; byte_nxt = byte_r; last_nxt = last_r;
    run_nxt = 1'b0; bit_nxt = bit_r;
    pv = 1'b0; pd = '0;
    c = byte_r;
    ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    nl = c == 8'd10; cr = c == 8'd13;
    sam = 1'b0; sv = '0; fin_tok = 1'b0;
    neg = 1'b0; bad = 1'b0; prod = '0; pix = '0; v8 = '0; c1 = '0;
    smp_go = 1'b0;
    if (cmd.load) begin
      byte_nxt = in_data.byte_value; last_nxt = in_data.last_byte;
    end else if (work && ferr_r == ERR_NONE) begin
      unique case (mode_r)
        PM_SEEK: if (nl) mode_nxt = PM_BINARY; else if (cr) mode_nxt = PM_AFTER_CR;
        PM_AFTER_CR, PM_BINARY: begin
          mode_nxt = PM_BINARY;
          if (!(mode_r == PM_AFTER_CR && nl)) begin
            if (full_f(wid_r, hgt_r, row_r)) begin
              ferr_nxt = ERR_EXCESS; pv = 1'b1; pd.kind = KIND_ERROR; pd.error_code = ERR_EXCESS;
            end else if (fmt_r == 3'd3) begin
              run_nxt = 1'b1; bit_nxt = 3'd0;
            end else if (c > maxv_r) begin
              ferr_nxt = ERR_SAMPLE; pv = 1'b1; pd.kind = KIND_ERROR; pd.error_code = ERR_SAMPLE;
            end else begin
              smp_go = 1'b1; sv = TW'(c);
            end
          end
        end
        default: begin
          // tokenizer
          if (tf_com_r) begin
            if (nl || cr) tf_com_nxt = 1'b0;
          end else if (tf_tok_r && ws) begin
            fin_tok = 1'b1;
          end else if (tf_tok_r || !ws) begin
            if (!tf_tok_r && c == 8'h23) tf_com_nxt = 1'b1;
            else begin
              if (!tf_tok_r) begin
                tf_tok_nxt = 1'b1; tf_neg_nxt = 1'b0; tf_bad_nxt = 1'b0;
                tok_nxt = '0; mp_nxt = 4'd0;
              end
              if (mode_r == PM_MAGIC) begin
                if ((tf_tok_r ? mp_r : 4'd0) == 4'd0 && c == 8'h50) mp_nxt = 4'd1;
                else if (tf_tok_r && mp_r == 4'd1 && c >= 8'h31 && c <= 8'h36)
                  mp_nxt = 4'(c - 8'h31 + 8'd2);
                else mp_nxt = 4'd15;
              end else if (!tf_tok_r && c == 8'h2D) tf_neg_nxt = 1'b1;
              else if (c >= 8'h30 && c <= 8'h39) begin
                prod = (TW+4)'(tf_tok_r ? tok_r : '0) * (TW+4)'(10) + (TW+4)'(c - 8'h30);
                tok_nxt = (prod > (TW+4)'(CAP)) ? CAP : prod[TW-1:0];
              end else tf_bad_nxt = 1'b1;
            end
          end
          if (last_r && !fin_tok && tf_tok_nxt && !tf_com_r) fin_tok = 1'b1;
          if (fin_tok) begin
            neg = tf_neg_nxt && tok_nxt != '0;
            bad = tf_bad_nxt;
            tf_tok_nxt = 1'b0; tf_neg_nxt = 1'b0; tf_bad_nxt = 1'b0;
            if (mode_r == PM_MAGIC) begin
              if (mp_nxt >= 4'd2 && mp_nxt <= 4'd7) begin
                fmt_nxt = 3'(mp_nxt - 4'd2); mode_nxt = PM_WIDTH;
              end else begin
                ferr_nxt = ERR_MAGIC; pv = 1'b1; pd.kind = KIND_ERROR; pd.error_code = ERR_MAGIC;
              end
            end else if (bad) begin
              ferr_nxt = ERR_NUMBER; pv = 1'b1; pd.kind = KIND_ERROR; pd.error_code = ERR_NUMBER;
            end else if (mode_r == PM_WIDTH || mode_r == PM_HEIGHT) begin
              if (neg || tok_nxt[TW-1]) begin
                ferr_nxt = ERR_SIZE; pv = 1'b1; pd.kind = KIND_ERROR; pd.error_code = ERR_SIZE;
              end else if (mode_r == PM_WIDTH) begin
                wid_nxt = tok_nxt[DIM_BITS-1:0]; mode_nxt = PM_HEIGHT;
              end else begin
                hgt_nxt = tok_nxt[DIM_BITS-1:0];
                if (fmt_r == 3'd0) mode_nxt = PM_ASCII;
                else if (fmt_r == 3'd3)
                  mode_nxt = (last_r && !ws) ? PM_SEEK : nl ? PM_BINARY : cr ? PM_AFTER_CR : PM_SEEK;
                else mode_nxt = PM_MAXVAL;
              end
            end else if (mode_r == PM_MAXVAL) begin
              if (neg || tok_nxt == '0 || tok_nxt > TW'(255)) begin
                ferr_nxt = ERR_MAXVAL; pv = 1'b1; pd.kind = KIND_ERROR; pd.error_code = ERR_MAXVAL;
              end else begin
                maxv_nxt = tok_nxt[7:0]; gscale_nxt = gray_div(tok_nxt[7:0]);
                if (fmt_r == 3'd1 || fmt_r == 3'd2) mode_nxt = PM_ASCII;
                else mode_nxt = (last_r && !ws) ? PM_SEEK : nl ? PM_BINARY : cr ? PM_AFTER_CR : PM_SEEK;
              end
            end else begin
              if (neg || tok_nxt > TW'(maxv_r)) begin
                ferr_nxt = ERR_SAMPLE; pv = 1'b1; pd.kind = KIND_ERROR; pd.error_code = ERR_SAMPLE;
              end else if (full_f(wid_r, hgt_r, row_r)) begin
                ferr_nxt = ERR_EXCESS; pv = 1'b1; pd.kind = KIND_ERROR; pd.error_code = ERR_EXCESS;
              end else begin
                smp_go = 1'b1; sv = tok_nxt;
              end
            end
          end
        end
      endcase
      // sample to pixel
      if (smp_go) begin
        v8 = sv[7:0];
        sam = 1'b0;
        if (fmt_r == 3'd0 || fmt_r == 3'd3) begin
          pix = (sv != '0) ? 8'd0 : 8'd255; sam = 1'b1;
        end else if (fmt_r == 3'd1 || fmt_r == 3'd4) begin
          pix = 8'(v8 * gscale_r); sam = 1'b1;
        end else if (ch_r == 2'd0) begin
          prg_nxt = {v8, 8'd0}; ch_nxt = 2'd1;
        end else if (ch_r == 2'd1) begin
          prg_nxt = {prg_r[15:8], v8}; ch_nxt = 2'd2;
        end else begin
          ch_nxt = 2'd0; sam = 1'b1;
        end
        if (sam) begin
          c1 = col_r + 1'b1;
          if (c1 >= wid_r) begin col_nxt = '0; row_nxt = row_r + 1'b1; end
          else col_nxt = c1;
          pv = 1'b1; pd.kind = KIND_PIXEL;
          if (fmt_r == 3'd2 || fmt_r == 3'd5) begin
            pd.red = prg_r[15:8]; pd.green = prg_r[7:0]; pd.blue = v8;
          end else begin
            pd.red = pix; pd.green = pix; pd.blue = pix;
          end
          pd.final_pixel = full_f(wid_r, hgt_r, row_nxt);
        end
      end
    end else if (cmd.run_bit) begin
      // one P4 bit pixel
      pix = byte_r[3'd7 - bit_r] ? 8'd0 : 8'd255;
      c1 = col_r + 1'b1;
      if (c1 >= wid_r) begin col_nxt = '0; row_nxt = row_r + 1'b1; end
      else col_nxt = c1;
      pv = 1'b1; pd.kind = KIND_PIXEL; pd.red = pix; pd.green = pix; pd.blue = pix;
      pd.final_pixel = full_f(wid_r, hgt_r, row_nxt);
      bit_nxt = bit_r + 1'b1;
    end else if (cmd.finish) begin
      pv = 1'b1; pd.kind = KIND_DONE; pd.error_code = ferr_r;
      if (ferr_r == ERR_NONE && (mode_r < PM_ASCII || !full_f(wid_r, hgt_r, row_r)))
        pd.error_code = ERR_SHORT;
    end
    pd.frame_width  = 16'(wid_r);
    pd.frame_height = 16'(hgt_r);
    if (cmd.finish) begin
      mode_nxt = PM_MAGIC; fmt_nxt = 3'd0; wid_nxt = '0; hgt_nxt = '0; maxv_nxt = 8'd1;
      gscale_nxt = 8'd255; tok_nxt = '0; tf_tok_nxt = 1'b0; tf_com_nxt = 1'b0;
      tf_neg_nxt = 1'b0; tf_bad_nxt = 1'b0; mp_nxt = '0; col_nxt = '0; row_nxt = '0;
      ch_nxt = '0; prg_nxt = '0; ferr_nxt = ERR_NONE;
    end
  end

  // end of run: last result for this byte
  logic more_run;
  assign more_run = (bit_r != 3'd7) && (row_nxt == row_r);
  always_comb begin
    res_valid = pv;
    res_data  = pd;
    if (cmd.finish) res_data.end_of_run = 1'b1;
    else if (cmd.run_bit) res_data.end_of_run = !more_run && !last_r;
    else res_data.end_of_run = pv && !run_nxt && !last_r;
  end

  // a P4 payload byte is known to start a run during its work step
  assign stat.has_run  = run_nxt;
  assign stat.run_more = more_run;
  assign stat.last     = last_r;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PM_MAGIC; fmt_r <= '0; wid_r <= '0; hgt_r <= '0; maxv_r <= 8'd1;
      gscale_r <= 8'd255; tok_r <= '0; tf_tok_r <= 1'b0; tf_com_r <= 1'b0;
      tf_neg_r <= 1'b0; tf_bad_r <= 1'b0; mp_r <= '0; col_r <= '0; row_r <= '0;
      ch_r <= '0; prg_r <= '0; ferr_r <= '0; last_r <= 1'b0;
      bit_r <= '0;
    end else if (cmd.load || work || cmd.run_bit || cmd.finish) begin
      mode_r <= mode_nxt; fmt_r <= fmt_nxt; wid_r <= wid_nxt; hgt_r <= hgt_nxt;
      maxv_r <= maxv_nxt; gscale_r <= gscale_nxt; tok_r <= tok_nxt;
      tf_tok_r <= tf_tok_nxt; tf_com_r <= tf_com_nxt; tf_neg_r <= tf_neg_nxt;
      tf_bad_r <= tf_bad_nxt; mp_r <= mp_nxt; col_r <= col_nxt; row_r <= row_nxt;
      ch_r <= ch_nxt; prg_r <= prg_nxt; ferr_r <= ferr_nxt; last_r <= last_nxt;
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

[hdl/netpbm_stream_decoder.sv]
// A byte is latched at its transfer, then processed in its work step (flagged
// by work_r) into the output register; a P4 payload byte's pixels start
// after the byte is examined. A byte is loaded and processed before the next;
// a P4 byte then runs its pixels (up to 8), and a final byte emits completion.
// Every step stalls while the output register holds a result not yet taken.
// Reset: synchronous active-low rst_n returns the parser to magic search.
// ----------------------------------------------------------------------------
// netpbm_stream_decoder
// Streaming PBM/PGM/PPM decoder producing RGB pixels, errors and completion.
// ----------------------------------------------------------------------------
module netpbm_stream_decoder
  import nsd_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  nsd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output nsd_out_t out_data
);

  nsd_cmd_t  cmd;
  nsd_stat_t stat;
  logic      res_valid, step_ok, work_r;
  nsd_out_t  res_data;
  logic      out_valid_r;
  nsd_out_t  out_data_r;

  // a step may run when the output register is free or draining
  assign step_ok = !out_valid_r || out_ready;

  // work flag registered from load, held while the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) work_r <= 1'b0;
    else if (step_ok) work_r <= cmd.load;
  end

  nsd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .step_ok, .stat, .cmd
  );

  nsd_dp #(.DIM_BITS(DIM_BITS)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .work(work_r && step_ok), .stat,
    .res_valid, .res_data
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (step_ok) out_valid_r <= res_valid;
  end
  always_ff @(posedge clk) begin
    if (step_ok && res_valid) out_data_r <= res_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/netpbm_stream_decoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// netpbm_stream_decoder_test
// Streams whole Netpbm files (all six formats, comments, broken headers, bad
// and excess samples, truncated files) into the decoder under random idling
// and backpressure, and checks each result against an in-bench decoder.
// ----------------------------------------------------------------------------
module netpbm_stream_decoder_test;
  import nsd_pkg::*;

  localparam int LIMIT = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  nsd_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  nsd_out_t out_data;

  netpbm_stream_decoder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Decoder state mirrored in the bench
  nsd_mode_t   dec_mode;
  logic [2:0]  dec_fmt;
  logic [31:0] dec_w, dec_h, dec_maxv, dec_gscale, dec_tok;
  logic [31:0] dec_col, dec_row, dec_rg;
  logic [3:0]  dec_tflags, dec_magic;
  logic [1:0]  dec_chan;
  logic [2:0]  dec_ferr;

  nsd_in_t  byte_queue[$];
  nsd_out_t expected_results[$];
  int       failures;
  int       cycle_count;
  bit       stim_done;
  bit       hold_sender;
  int       rx_holdoff;
  bit       quiet;

  localparam logic [3:0] TF_TOKEN = 4'd1;
  localparam logic [3:0] TF_COMMENT = 4'd2;
  localparam logic [3:0] TF_NEG = 4'd4;
  localparam logic [3:0] TF_BAD = 4'd8;

  function automatic void clear_decoder();
    dec_mode = PM_MAGIC; dec_fmt = 0; dec_w = 0; dec_h = 0; dec_maxv = 1;
    dec_gscale = 255; dec_tok = 0; dec_tflags = 0; dec_magic = 0; dec_col = 0;
    dec_row = 0; dec_chan = 0; dec_rg = 0; dec_ferr = ERR_NONE;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, logic [2:0] e, logic fin);
    nsd_out_t o;
    o.kind = k; o.red = r; o.green = g; o.blue = b; o.error_code = e;
    o.frame_width = dec_w[15:0]; o.frame_height = dec_h[15:0];
    o.final_pixel = fin; o.end_of_run = 1'b0;
    expected_results.insert(expected_results.size(), o);
  endfunction

  function automatic void flag_error(logic [2:0] code);
    if (dec_ferr == ERR_NONE) begin
      dec_ferr = code;
      push_result(KIND_ERROR, 0, 0, 0, code, 0);
    end
  endfunction

  function automatic bit image_done();
    return dec_w == 0 || dec_h == 0 || dec_row >= dec_h;
  endfunction

  function automatic void emit_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    dec_col++;
    if (dec_col >= dec_w) begin
      dec_col = 0;
      dec_row++;
    end
    push_result(KIND_PIXEL, r, g, b, ERR_NONE, image_done());
  endfunction

  function automatic void take_sample(logic [31:0] v);
    logic [7:0] c;
    if (dec_fmt == 0 || dec_fmt == 3) begin
      c = (v != 0) ? 8'd0 : 8'd255;
      emit_pixel(c, c, c);
    end else if (dec_fmt == 1 || dec_fmt == 4) begin
      c = 8'(v * dec_gscale);
      emit_pixel(c, c, c);
    end else if (dec_chan == 0) begin
      dec_rg = v << 8; dec_chan = 1;
    end else if (dec_chan == 1) begin
      dec_rg = dec_rg | v; dec_chan = 2;
    end else begin
      dec_chan = 0;
      emit_pixel(dec_rg[15:8], dec_rg[7:0], v[7:0]);
    end
  endfunction

  function automatic void go_binary(int term);
    dec_mode = (term == 10) ? PM_BINARY : (term == 13) ? PM_AFTER_CR : PM_SEEK;
  endfunction

  function automatic void close_token(int term);
    logic [31:0] v;
    bit neg, bad;
    v = dec_tok;
    neg = (dec_tflags & TF_NEG) != 0 && v != 0;
    bad = (dec_tflags & TF_BAD) != 0;
    dec_tflags = dec_tflags & ~(TF_TOKEN | TF_NEG | TF_BAD);
    if (dec_mode == PM_MAGIC) begin
      if (dec_magic >= 2 && dec_magic <= 7) begin
        dec_fmt = 3'(dec_magic - 2);
        dec_mode = PM_WIDTH;
      end else begin
        flag_error(ERR_MAGIC);
      end
    end else if (bad) begin
      flag_error(ERR_NUMBER);
    end else if (dec_mode == PM_WIDTH || dec_mode == PM_HEIGHT) begin
      if (neg || v >= 32'h10000) begin
        flag_error(ERR_SIZE);
      end else if (dec_mode == PM_WIDTH) begin
        dec_w = v; dec_mode = PM_HEIGHT;
      end else begin
        dec_h = v;
        if (dec_fmt == 0) dec_mode = PM_ASCII;
        else if (dec_fmt == 3) go_binary(term);
        else dec_mode = PM_MAXVAL;
      end
    end else if (dec_mode == PM_MAXVAL) begin
      if (neg || v == 0 || v > 255) begin
        flag_error(ERR_MAXVAL);
      end else begin
        dec_maxv = v;
        dec_gscale = 255 / v;
        if (dec_fmt == 1 || dec_fmt == 2) dec_mode = PM_ASCII;
        else go_binary(term);
      end
    end else begin
      if (neg || v > dec_maxv) flag_error(ERR_SAMPLE);
      else if (image_done()) flag_error(ERR_EXCESS);
      else take_sample(v);
    end
  endfunction

  function automatic void token_char(logic [7:0] c, bit first);
    logic [31:0] nv;
    if (dec_mode == PM_MAGIC) begin
      if (dec_magic == 0 && c == "P") dec_magic = 1;
      else if (dec_magic == 1 && c >= "1" && c <= "6") dec_magic = 4'(2 + c - "1");
      else dec_magic = 15;
    end else if (first && c == "-") begin
      dec_tflags |= TF_NEG;
    end else if (c >= "0" && c <= "9") begin
      nv = dec_tok * 10 + (c - "0");
      dec_tok = (nv > 32'h1FFFF) ? 32'h1FFFF : nv;
    end else begin
      dec_tflags |= TF_BAD;
    end
  endfunction

  function automatic void header_byte(logic [7:0] c);
    bit ws;
    ws = c == " " || (c >= 9 && c <= 13);
    if (dec_tflags & TF_COMMENT) begin
      if (c == 10 || c == 13) dec_tflags &= ~TF_COMMENT;
    end else if (dec_tflags & TF_TOKEN) begin
      if (ws) close_token(c);
      else token_char(c, 0);
    end else if (!ws) begin
      if (c == "#") begin
        dec_tflags |= TF_COMMENT;
      end else begin
        dec_tflags = TF_TOKEN; dec_tok = 0; dec_magic = 0;
        token_char(c, 1);
      end
    end
  endfunction

  function automatic void payload_byte(logic [7:0] c);
    logic [7:0] bits;
    logic [31:0] row;
    if (image_done()) begin
      flag_error(ERR_EXCESS);
    end else if (dec_fmt == 3) begin
      bits = c;
      for (int i = 0; i < 8; i++) begin
        row = dec_row;
        emit_pixel(bits[7] ? 8'd0 : 8'd255, bits[7] ? 8'd0 : 8'd255,
                   bits[7] ? 8'd0 : 8'd255);
        bits = bits << 1;
        if (dec_row != row) break;
      end
    end else if (c > dec_maxv) begin
      flag_error(ERR_SAMPLE);
    end else begin
      take_sample(c);
    end
  endfunction

  // Work out every result that one accepted byte causes
  function automatic void decode_byte(nsd_in_t it);
    int n0;
    logic [2:0] e;
    n0 = expected_results.size();
    if (dec_ferr == ERR_NONE) begin
      if (dec_mode == PM_SEEK) begin
        if (it.byte_value == 10) dec_mode = PM_BINARY;
        else if (it.byte_value == 13) dec_mode = PM_AFTER_CR;
      end else if (dec_mode == PM_AFTER_CR) begin
        dec_mode = PM_BINARY;
        if (it.byte_value != 10) payload_byte(it.byte_value);
      end else if (dec_mode == PM_BINARY) begin
        payload_byte(it.byte_value);
      end else begin
        header_byte(it.byte_value);
        if (it.last_byte && dec_ferr == ERR_NONE && (dec_tflags & TF_TOKEN))
          close_token(256);
      end
    end
    if (it.last_byte) begin
      e = dec_ferr;
      if (e == ERR_NONE && (dec_mode < PM_ASCII || !image_done())) e = ERR_SHORT;
      push_result(KIND_DONE, 0, 0, 0, e, 0);
      clear_decoder();
    end
    if (expected_results.size() > n0)
      expected_results[expected_results.size() - 1].end_of_run = 1'b1;
  endfunction

  // Stimulus building
  function automatic void put_str(string s);
    nsd_in_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.byte_value = s[i]; it.last_byte = 1'b0;
      byte_queue.insert(byte_queue.size(), it);
    end
  endfunction

  function automatic void put_byte(logic [7:0] b);
    nsd_in_t it;
    it.byte_value = b; it.last_byte = 1'b0;
    byte_queue.insert(byte_queue.size(), it);
  endfunction

  function automatic void end_file(logic [7:0] b);
    nsd_in_t it;
    it.byte_value = b; it.last_byte = 1'b1;
    byte_queue.insert(byte_queue.size(), it);
  endfunction

  function automatic string sep();
    case ($urandom_range(0, 5))
      0: return "\n";
      1: return "\t";
      2: return " # note\n ";
      3: return "\r\n";
      default: return " ";
    endcase
  endfunction

  // One random file: mostly well formed, some broken
  function automatic void random_file();
    int fmt, w, h, mv, n, flaw;
    fmt = $urandom_range(1, 6);
    w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    h = $urandom_range(1, 3);
    mv = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255);
    flaw = $urandom_range(0, 9);
    put_str($sformatf("P%0d%s%0d%s%0d", fmt, sep(), w, sep(), h));
    if (fmt != 1 && fmt != 4) put_str($sformatf("%s%0d", sep(), mv));
    if (fmt <= 3) begin
      n = w * h * (fmt == 3 ? 3 : 1) + ((flaw == 0) ? 1 : 0) - ((flaw == 1) ? 1 : 0);
      for (int i = 0; i < n; i++) begin
        if (fmt == 1) put_str($sformatf("%s%0d", sep(), $urandom_range(0, 1)));
        else if (flaw == 2 && i == 0) put_str($sformatf(" %0d", mv + 1));
        else put_str($sformatf("%s%0d", sep(), $urandom_range(0, mv)));
      end
      end_file(" ");
    end else begin
      if ($urandom_range(0, 1) == 0) put_str("\n");
      else put_str(" x\r\n");
      n = (fmt == 4) ? h * ((w + 7) / 8) : w * h * (fmt == 6 ? 3 : 1);
      n = n + ((flaw == 0) ? 1 : 0) - ((flaw == 1 && n > 0) ? 1 : 0);
      for (int i = 0; i < n; i++) begin
        if (flaw == 2 && i == 0 && mv < 255) put_byte(8'(mv + 1));
        else put_byte(8'(fmt == 4 ? $urandom_range(0, 255) : $urandom_range(0, mv)));
      end
      end_file(8'($urandom_range(0, 255)));
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Fill the byte queue: directed files, then random ones
  initial begin
    failures = 0;
    stim_done = 0;
    put_str("P1 2 2 1 0\n0 1"); end_file("\n");
    put_str("P2 # hi\n2 1 255 0 255"); end_file(" ");
    put_str("P3 1 1 3 1 2 3"); end_file("\t");
    put_str("P4 9 1\r\n"); put_byte(8'hA5); end_file(8'h80);
    put_str("P5 1 2 7 junk\r"); put_byte(8'd0); end_file(8'd7);
    put_str("P6 1 1 255\n"); put_byte(8'hFF); put_byte(8'h00); end_file(8'h55);
    put_str("P7"); end_file(" ");
    put_str("P2 -0 2"); end_file(" ");
    put_str("P2 65536 1"); end_file("\n");
    put_str("P2 1 1 0"); end_file(" ");
    put_str("P2 1 1 9 -3"); end_file(" ");
    put_str("P2 1 1 9 1 2"); end_file(" ");
    put_str("P2 1x"); end_file(" ");
    put_str("P3 9999999999 1"); end_file(" ");
    put_str("P5 2 2 255\n"); put_byte(8'h7F); end_file(8'h80);
    end_file(8'hFF);
    while (byte_queue.size() < 480) random_file();
    stim_done = 1;
  end

  // Receiver: a stretch with no idling, then one long hold-off counted here
  initial begin
    rx_holdoff = 0;
    quiet = 0;
    wait (rst_n);
    repeat (200) @(posedge clk);
    quiet = 1;
    repeat (400) @(posedge clk);
    quiet = 0;
    repeat (200) @(posedge clk);
    rx_holdoff = 300;
    repeat (300) @(posedge clk);
    rx_holdoff = 0;
  end

  // Sender pause until everything expected has arrived, once
  initial begin
    hold_sender = 0;
    wait (rst_n);
    while (byte_queue.size() >= 200) @(posedge clk);
    hold_sender = 1;
    do @(posedge clk); while (expected_results.size() != 0);
    hold_sender <= 0;
  end

  // Reset and drive inputs
  always @(posedge clk) begin
    if (cycle_count < 2) begin
      rst_n <= 1'b0;
      in_valid <= 1'b0;
      in_data <= '0;
      out_ready <= 1'b0;
      clear_decoder();
    end else begin
      rst_n <= 1'b1;
      if (in_valid && in_ready) decode_byte(in_data);
      if (!in_valid || in_ready) begin
        if (byte_queue.size() > 0 && !hold_sender && rst_n &&
            (quiet || $urandom_range(0, 99) >= 23)) begin
          in_valid <= 1'b1;
          in_data <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= (rx_holdoff == 0) && (quiet || $urandom_range(0, 99) >= 23);
    end
  end

  // Check each transfer on the result channel
  always @(posedge clk) begin
    nsd_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind %0d", out_data.kind);
        failures++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.kind !== exp_r.kind) begin
          $error("kind exp %0d got %0d", exp_r.kind, out_data.kind); failures++;
        end
        if (out_data.red !== exp_r.red) begin
          $error("red exp %0d got %0d", exp_r.red, out_data.red); failures++;
        end
        if (out_data.green !== exp_r.green) begin
          $error("green exp %0d got %0d", exp_r.green, out_data.green); failures++;
        end
        if (out_data.blue !== exp_r.blue) begin
          $error("blue exp %0d got %0d", exp_r.blue, out_data.blue); failures++;
        end
        if (out_data.error_code !== exp_r.error_code) begin
          $error("error_code exp %0d got %0d", exp_r.error_code, out_data.error_code);
          failures++;
        end
        if (out_data.frame_width !== exp_r.frame_width) begin
          $error("frame_width exp %0d got %0d", exp_r.frame_width, out_data.frame_width);
          failures++;
        end
        if (out_data.frame_height !== exp_r.frame_height) begin
          $error("frame_height exp %0d got %0d", exp_r.frame_height,
                 out_data.frame_height);
          failures++;
        end
        if (out_data.final_pixel !== exp_r.final_pixel) begin
          $error("final_pixel exp %0d got %0d", exp_r.final_pixel, out_data.final_pixel);
          failures++;
        end
        if (out_data.end_of_run !== exp_r.end_of_run) begin
          $error("end_of_run exp %0d got %0d", exp_r.end_of_run, out_data.end_of_run);
          failures++;
        end
      end
    end
  end

  // Cycle counter with timeout
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (byte_queue.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
